// ===== hw/rtl/pcs_pkg.sv =====
`default_nettype none
package pcs_pkg;
   localparam int BIN_COUNT = 256;
   localparam int CHANNELS = 3;
   localparam int BIN_W = 23;
   localparam int SUM_W = 31;
   localparam logic [BIN_W-1:0] MAX_PIXELS = 23'd4194304;

   localparam logic [1:0] KIND_COUNT = 2'd0;
   localparam logic [1:0] KIND_FINISH = 2'd1;
   localparam logic [1:0] KIND_MAP = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/percentile_color_stretch.sv =====
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_data   (kind, red/green/blue samples)
// rsp       out        rsp_valid/rsp_stall   rsp_data   (stretched samples, map only)
// csr       in         csr_wr_en             csr_wr_data (tail count)
// A count request does a histogram read, then a write back.
// A finish request does a two-port walk of the 256 bins, commit,
// then a clearing pass over all bins.
// A map request runs the 16-step restoring divider.
// After reset the input stalls for the same clearing pass over all bins.
// The result sits in an output register; a new request is taken while it stalls.
`default_nettype none
module percentile_color_stretch (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pcs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pcs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [22:0]      csr_wr_data
);
   import pcs_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CNT = 4'd1;
   localparam logic [3:0] ST_SCAN = 4'd2;
   localparam logic [3:0] ST_DRAIN = 4'd3;
   localparam logic [3:0] ST_FIN = 4'd4;
   localparam logic [3:0] ST_MAP = 4'd5;
   localparam logic [3:0] ST_DIV = 4'd6;
   localparam logic [3:0] ST_OUT = 4'd7;
   localparam logic [3:0] ST_CLR = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [22:0] tail_ff;
   req_type req_ff;
   logic [7:0] scan_cnt_ff;
   logic pr_vld_ff;
   logic [7:0] pr_idx_ff;
   logic [3:0] div_cnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic out_load;

   logic [7:0] samp [CHANNELS];
   logic [7:0] addr_a [CHANNELS];
   logic [7:0] addr_b;
   logic [BIN_W-1:0] rda_ff [CHANNELS];
   logic [BIN_W-1:0] rdb_ff [CHANNELS];
   logic [BIN_W-1:0] bin_a [CHANNELS];
   logic [BIN_W-1:0] bin_b [CHANNELS];

   logic [SUM_W-1:0] lo_sum_ff [CHANNELS];
   logic [SUM_W-1:0] hi_sum_ff [CHANNELS];
   logic signed [8:0] lo_t_ff [CHANNELS];
   logic signed [8:0] hi_t_ff [CHANNELS];
   logic signed [8:0] low_cuts_ff [CHANNELS];
   logic signed [8:0] high_cuts_ff [CHANNELS];

   logic byp_ff [CHANNELS];
   logic [7:0] byp_val_ff [CHANNELS];
   logic [15:0] num_ff [CHANNELS];
   logic [8:0] den_ff [CHANNELS];
   logic [9:0] rem_ff [CHANNELS];
   logic [15:0] quo_ff [CHANNELS];

   assign samp[0] = req_ff.red_in;
   assign samp[1] = req_ff.green_in;
   assign samp[2] = req_ff.blue_in;
   assign addr_a[0] = (state_ff == ST_IDLE) ? req_data.red_in :
                      (state_ff == ST_SCAN) ? scan_cnt_ff : req_ff.red_in;
   assign addr_a[1] = (state_ff == ST_IDLE) ? req_data.green_in :
                      (state_ff == ST_SCAN) ? scan_cnt_ff : req_ff.green_in;
   assign addr_a[2] = (state_ff == ST_IDLE) ? req_data.blue_in :
                      (state_ff == ST_SCAN) ? scan_cnt_ff : req_ff.blue_in;
   assign addr_b = ~scan_cnt_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.kind)
                  KIND_COUNT: state_in = ST_CNT;
                  KIND_FINISH: state_in = ST_SCAN;
                  KIND_MAP: state_in = ST_MAP;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CNT: state_in = ST_IDLE;
         ST_SCAN: if (scan_cnt_ff == 8'd255) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_FIN;
         ST_FIN: state_in = ST_CLR;
         ST_CLR: if (scan_cnt_ff == 8'd255) state_in = ST_IDLE;
         ST_MAP: state_in = ST_DIV;
         ST_DIV: if (div_cnt_ff == 4'd15) state_in = ST_OUT;
         ST_OUT: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         tail_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pr_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) tail_ff <= csr_wr_data;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         pr_vld_ff <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
      end else if (state_ff == ST_IDLE) begin
         scan_cnt_ff <= '0;
      end else if (state_ff == ST_SCAN || state_ff == ST_CLR) begin
         scan_cnt_ff <= scan_cnt_ff + 8'd1;
      end
      if (state_ff == ST_IDLE) req_ff <= req_data;
      pr_idx_ff <= scan_cnt_ff;
      if (state_ff == ST_MAP) div_cnt_ff <= '0;
      else div_cnt_ff <= div_cnt_ff + 4'd1;
      if (out_load) begin
         rsp_ff.red_out <= byp_ff[0] ? byp_val_ff[0] : quo_ff[0][7:0];
         rsp_ff.green_out <= byp_ff[1] ? byp_val_ff[1] : quo_ff[1][7:0];
         rsp_ff.blue_out <= byp_ff[2] ? byp_val_ff[2] : quo_ff[2][7:0];
      end
   end

   genvar gc;
   for (gc = 0; gc < CHANNELS; gc++) begin : g_ch
      logic [BIN_W-1:0] mem [BIN_COUNT];
      logic [BIN_W-1:0] bump_val;
      logic signed [8:0] v_s;
      logic [7:0] dl;
      logic [9:0] trial;

      assign bin_a[gc] = rda_ff[gc];
      assign bin_b[gc] = rdb_ff[gc];
      assign bump_val = (bin_a[gc] < MAX_PIXELS) ? bin_a[gc] + 23'd1 : bin_a[gc];
      assign v_s = $signed({1'b0, samp[gc]});
      assign dl = 8'(v_s - low_cuts_ff[gc]);
      assign trial = {rem_ff[gc][8:0], num_ff[gc][15]};

      always_ff @(posedge clock) begin
         if (state_ff == ST_CNT) mem[samp[gc]] <= bump_val;
         else if (state_ff == ST_CLR) mem[scan_cnt_ff] <= '0;
         rda_ff[gc] <= mem[addr_a[gc]];
         rdb_ff[gc] <= mem[addr_b];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            low_cuts_ff[gc] <= -9'sd1;
            high_cuts_ff[gc] <= -9'sd1;
         end else if (state_ff == ST_FIN) begin
            low_cuts_ff[gc] <= lo_t_ff[gc];
            high_cuts_ff[gc] <= hi_t_ff[gc];
         end
      end

      always_ff @(posedge clock) begin
         if (state_ff == ST_IDLE) begin
            lo_sum_ff[gc] <= '0;
            hi_sum_ff[gc] <= '0;
            lo_t_ff[gc] <= -9'sd1;
            hi_t_ff[gc] <= -9'sd1;
         end else if (pr_vld_ff) begin
            if (lo_t_ff[gc][8] && lo_sum_ff[gc] >= SUM_W'(tail_ff))
               lo_t_ff[gc] <= $signed({1'b0, pr_idx_ff});
            if (hi_t_ff[gc][8] && hi_sum_ff[gc] >= SUM_W'(tail_ff))
               hi_t_ff[gc] <= $signed({1'b0, ~pr_idx_ff});
            lo_sum_ff[gc] <= lo_sum_ff[gc] + SUM_W'(bin_a[gc]);
            hi_sum_ff[gc] <= hi_sum_ff[gc] + SUM_W'(bin_b[gc]);
         end
      end

      always_ff @(posedge clock) begin
         if (state_ff == ST_MAP) begin
            byp_ff[gc] <= (v_s <= low_cuts_ff[gc]) || (v_s >= high_cuts_ff[gc]);
            byp_val_ff[gc] <= (v_s <= low_cuts_ff[gc]) ? 8'd0 : 8'd255;
            num_ff[gc] <= {dl, 8'd0} - {8'd0, dl};
            den_ff[gc] <= 9'(high_cuts_ff[gc] - low_cuts_ff[gc]);
            rem_ff[gc] <= '0;
            quo_ff[gc] <= '0;
         end else if (state_ff == ST_DIV) begin
            num_ff[gc] <= {num_ff[gc][14:0], 1'b0};
            if (trial >= {1'b0, den_ff[gc]}) begin
               rem_ff[gc] <= trial - {1'b0, den_ff[gc]};
               quo_ff[gc] <= {quo_ff[gc][14:0], 1'b1};
            end else begin
               rem_ff[gc] <= trial;
               quo_ff[gc] <= {quo_ff[gc][14:0], 1'b0};
            end
         end
      end
   end

   a_rsp_from_map: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("response without map request");
   a_fin_to_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |=> state_ff == ST_CLR)
      else $error("histogram clear not started after finish");
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      pr_vld_ff && $past(pr_vld_ff) |-> pr_idx_ff == $past(pr_idx_ff) + 8'd1)
      else $error("bin walk out of order");
endmodule
`default_nettype wire

// ===== test/tb_percentile_color_stretch.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_percentile_color_stretch;
   import pcs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [22:0] csr_wr_data = '0;

   percentile_color_stretch dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   localparam int TOP = 255;
   localparam int NONE = -1;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   req_type pending_reqs[$];
   rsp_type expected_pixels[$];
   int unsigned hist[3][256];
   int low_cut[3];
   int high_cut[3];
   int unsigned tail_count;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_off = 0;
   int fail_count = 0;
   int map_count = 0;
   int finish_count = 0;
   int sent_count = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] stretch_sample(int v, int lo, int hi);
      if (v <= lo) return 8'd0;
      if (v >= hi) return 8'd255;
      return 8'((TOP * (v - lo)) / (hi - lo));
   endfunction

   task automatic apply_request(req_type r);
      int v[3];
      longint lo_sum;
      longint hi_sum;
      rsp_type p;
      v[0] = r.red_in;
      v[1] = r.green_in;
      v[2] = r.blue_in;
      case (r.kind)
         KIND_COUNT: begin
            for (int c = 0; c < 3; c++)
               if (hist[c][v[c]] < MAX_PIXELS) hist[c][v[c]]++;
         end
         KIND_FINISH: begin
            finish_count++;
            for (int c = 0; c < 3; c++) begin
               lo_sum = 0;
               hi_sum = 0;
               low_cut[c] = NONE;
               high_cut[c] = NONE;
               for (int i = 0; i < 256; i++) begin
                  if (low_cut[c] == NONE && lo_sum >= tail_count) low_cut[c] = i;
                  if (high_cut[c] == NONE && hi_sum >= tail_count) high_cut[c] = TOP - i;
                  lo_sum += hist[c][i];
                  hi_sum += hist[c][TOP - i];
               end
               for (int i = 0; i < 256; i++) hist[c][i] = 0;
            end
         end
         KIND_MAP: begin
            p.red_out = stretch_sample(v[0], low_cut[0], high_cut[0]);
            p.green_out = stretch_sample(v[1], low_cut[1], high_cut[1]);
            p.blue_out = stretch_sample(v[2], low_cut[2], high_cut[2]);
            expected_pixels.push_back(p);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_request(req_data);
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            map_count++;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel %h", $realtime, rsp_data);
               fail_count++;
            end else begin
               if (rsp_data !== expected_pixels[0]) begin
                  $display("%0t: pixel mismatch expected %h actual %h",
                           $realtime, expected_pixels[0], rsp_data);
                  fail_count++;
               end
               void'(expected_pixels.pop_front());
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   function automatic req_type make_req(logic [1:0] k, int r, int g, int b);
      req_type q;
      q.kind = k;
      q.red_in = 8'(r);
      q.green_in = 8'(g);
      q.blue_in = 8'(b);
      return q;
   endfunction

   task automatic drain();
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_pixels.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_tail(int unsigned t);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= 23'(t);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tail_count = t & 23'h7FFFFF;
   endtask

   task automatic random_frame(int pixels, int maps);
      int r0;
      r0 = $urandom_range(255);
      for (int i = 0; i < pixels; i++)
         if ($urandom_range(9) == 0)
            pending_reqs.push_back(make_req(2'($urandom_range(3)), $urandom, $urandom,
                                            $urandom));
         else
            pending_reqs.push_back(make_req(KIND_COUNT, (r0 + $urandom_range(60)) % 256,
                                            $urandom, $urandom_range(255, 128)));
      pending_reqs.push_back(make_req(KIND_FINISH, 0, 0, 0));
      for (int i = 0; i < maps; i++)
         pending_reqs.push_back(make_req(KIND_MAP, $urandom, $urandom, $urandom));
   endtask

   initial begin
      tail_count = 0;
      for (int c = 0; c < 3; c++) begin
         low_cut[c] = NONE;
         high_cut[c] = NONE;
         for (int i = 0; i < 256; i++) hist[c][i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_idle = 29;
      recv_idle = 51;

      pending_reqs.push_back(make_req(KIND_MAP, 0, 128, 255));
      pending_reqs.push_back(make_req(KIND_UNUSED, 255, 255, 255));
      pending_reqs.push_back(make_req(KIND_FINISH, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_MAP, 0, 1, 255));
      drain();
      write_tail(2);
      for (int i = 0; i < 6; i++)
         pending_reqs.push_back(make_req(KIND_COUNT, 10 + i, 255 * (i % 2), 40));
      pending_reqs.push_back(make_req(KIND_FINISH, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_MAP, 10, 0, 40));
      pending_reqs.push_back(make_req(KIND_MAP, 13, 255, 39));
      pending_reqs.push_back(make_req(KIND_MAP, 15, 128, 41));
      pending_reqs.push_back(make_req(KIND_MAP, 12, 1, 255));
      drain();
      write_tail(23'h7FFFFF);
      pending_reqs.push_back(make_req(KIND_COUNT, 255, 0, 7));
      pending_reqs.push_back(make_req(KIND_FINISH, 0, 0, 0));
      pending_reqs.push_back(make_req(KIND_MAP, 200, 0, 255));
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin
            send_idle = 51;
            recv_idle = 29;
         end else if (ph == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_tail(ph == 4 ? 0 : $urandom_range(40));
         random_frame(80, 40);
         if (ph == 7) begin
            wait (pending_reqs.size() <= 40);
            hold_off = 1500;
         end
         drain();
      end

      $display("covered %0d requests, %0d finishes and %0d checked pixels",
               sent_count, finish_count, map_count);
      $display("tail counts from zero to full scale, idle mixes and a long output hold");
      if (fail_count == 0) begin
         $display("percentile_color_stretch regression: pass");
      end else begin
         $display("percentile_color_stretch regression: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("percentile_color_stretch regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/pcs_pkg.sv
hw/rtl/percentile_color_stretch.sv
test/tb_percentile_color_stretch.sv
